// ===== rtl/stt_pkg.sv =====
// shared types and constants for the software timer table
// holds the item structs, the chain link struct, op and status codes and fsm states
// no dependencies
package stt_pkg;

	localparam int DEFAULT_SLOTS = 16;
	localparam logic [31:0] NO_DEADLINE = 32'hffff_ffff;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_POLL   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  event_id;
		logic [31:0] delay_ms;
		logic        periodic;
		logic [31:0] now_ms;
	} req_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic       fired;
		logic [7:0] fired_event;
		logic [3:0] fired_slot;
	} rsp_item_t;

	// command held steady for the whole pass along the chain
	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  event_id;
		logic [31:0] period;
		logic        repeat_en;
		logic [31:0] add_dl;
		logic        fire_en;
	} cmd_t;

	// bundle handed from one cell to the next
	typedef struct packed {
		logic        tok;
		logic        found;
		logic [31:0] hit_dl;
		logic [7:0]  hit_event;
		logic        min_valid;
		logic [31:0] min_dl;
	} link_t;

endpackage

// ===== rtl/software_timer_table.sv =====
// top level of the software timer table: handshakes, command register,
// the chain of slot cells and the earliest-deadline tracking
// depends on stt_pkg and stt_cell
//
// usage:
//   req channel (req_valid/req_ready/req) takes one command item: add, remove or
//   poll, each with its time stamp. rsp channel (rsp_valid/rsp_ready/rsp) returns
//   exactly one result item per command, in order.
//   every command sends one token down the chain of SLOTS cells, one cell per
//   cycle; each cell searches, updates its own slot and folds its deadline into
//   the running minimum. the finished pass is captured at the end of the chain
//   and enters the output register once any previous result has been taken, and
//   req_ready rises only after that load: a new item is not taken while the
//   previous command is still in the chain or waits to enter the output register.
//   req_ready is high while no command is in the chain, including while a
//   previous result still waits in the output register. if the receiver stalls,
//   the finished command waits at the end of the chain until the output
//   register frees, then the tracked earliest deadline is updated.
//   after reset all slots are free, no deadline is tracked and both channels
//   are empty; no clearing pass is needed.
module software_timer_table #(
	parameter int SLOTS = stt_pkg::DEFAULT_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  stt_pkg::req_item_t    req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output stt_pkg::rsp_item_t    rsp
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	stt_pkg::state_t state_q, state_n;

	stt_pkg::cmd_t     cmd_q;
	logic [SLOT_W-1:0] fire_slot_q;
	logic              start_q;

	logic [31:0]       earliest_dl_q;
	logic [SLOT_W-1:0] earliest_slot_q;
	logic              earliest_valid_q;

	stt_pkg::link_t    fin_q;
	logic [SLOT_W-1:0] fin_min_slot_q;
	logic [SLOT_W-1:0] fin_hit_slot_q;

	stt_pkg::rsp_item_t rsp_q;
	logic               rsp_valid_q;

	stt_pkg::link_t    link     [SLOTS+1];
	logic [SLOT_W-1:0] min_slot [SLOTS+1];
	logic [SLOT_W-1:0] hit_slot [SLOTS+1];

	logic accept, latch_fin, load_rsp;

	assign accept = req_valid && req_ready;

	// chain head
	always_comb begin
		link[0]           = '0;
		link[0].tok       = start_q;
		link[0].min_dl    = stt_pkg::NO_DEADLINE;
		min_slot[0]       = '0;
		hit_slot[0]       = '0;
	end

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		stt_cell #(
			.SLOT_W(SLOT_W),
			.INDEX (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd_q),
			.fire_slot  (fire_slot_q),
			.up         (link[i]),
			.up_min_slot(min_slot[i]),
			.up_hit_slot(hit_slot[i]),
			.dn         (link[i+1]),
			.dn_min_slot(min_slot[i+1]),
			.dn_hit_slot(hit_slot[i+1])
		);
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			stt_pkg::ST_IDLE: begin
				if (req_valid) state_n = stt_pkg::ST_SCAN;
			end
			stt_pkg::ST_SCAN: begin
				if (link[SLOTS].tok) state_n = stt_pkg::ST_FINISH;
			end
			stt_pkg::ST_FINISH: begin
				if (!rsp_valid_q || rsp_ready) state_n = stt_pkg::ST_IDLE;
			end
			default: state_n = stt_pkg::ST_IDLE;
		endcase
	end

	// outputs of the fsm
	always_comb begin
		req_ready = 1'b0;
		latch_fin = 1'b0;
		load_rsp  = 1'b0;
		unique case (state_q)
			stt_pkg::ST_IDLE:   req_ready = 1'b1;
			stt_pkg::ST_SCAN:   latch_fin = link[SLOTS].tok;
			stt_pkg::ST_FINISH: load_rsp  = !rsp_valid_q || rsp_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stt_pkg::ST_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_n;
			start_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.op        <= req.op;
			cmd_q.event_id  <= req.event_id;
			cmd_q.period    <= req.delay_ms;
			cmd_q.repeat_en <= req.periodic;
			cmd_q.add_dl    <= req.now_ms + req.delay_ms;
			cmd_q.fire_en   <= earliest_valid_q && (req.now_ms >= earliest_dl_q);
			fire_slot_q     <= earliest_slot_q;
		end
		if (latch_fin) begin
			fin_q          <= link[SLOTS];
			fin_min_slot_q <= min_slot[SLOTS];
			fin_hit_slot_q <= hit_slot[SLOTS];
		end
	end

	// result and earliest-deadline update from the finished pass
	logic              is_add, is_rem, is_poll, refresh, add_wins;
	logic [7:0]        hit_slot_ext;
	stt_pkg::rsp_item_t rsp_n;

	always_comb begin
		is_add   = cmd_q.op == stt_pkg::OP_ADD;
		is_rem   = cmd_q.op == stt_pkg::OP_REMOVE;
		is_poll  = cmd_q.op == stt_pkg::OP_POLL;
		add_wins = is_add && fin_q.found &&
			(!earliest_valid_q || (fin_q.hit_dl < earliest_dl_q));
		refresh  = fin_q.found &&
			((is_rem && (fin_q.hit_dl == earliest_dl_q)) || is_poll);
		hit_slot_ext = 8'(fin_hit_slot_q);

		rsp_n = '0;
		if (is_add && !fin_q.found) begin
			rsp_n.status = stt_pkg::STATUS_FULL;
		end else if (is_rem && !fin_q.found) begin
			rsp_n.status = stt_pkg::STATUS_NOT_FOUND;
		end else begin
			rsp_n.status = stt_pkg::STATUS_OK;
		end
		if (is_poll && fin_q.found) begin
			rsp_n.fired       = 1'b1;
			rsp_n.fired_event = fin_q.hit_event;
			rsp_n.fired_slot  = hit_slot_ext[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			earliest_dl_q    <= stt_pkg::NO_DEADLINE;
			earliest_slot_q  <= '0;
			earliest_valid_q <= 1'b0;
			rsp_valid_q      <= 1'b0;
		end else begin
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
				if (add_wins) begin
					earliest_dl_q    <= fin_q.hit_dl;
					earliest_slot_q  <= fin_hit_slot_q;
					earliest_valid_q <= 1'b1;
				end else if (refresh) begin
					earliest_valid_q <= fin_q.min_valid;
					earliest_dl_q    <= fin_q.min_valid ? fin_q.min_dl : stt_pkg::NO_DEADLINE;
					earliest_slot_q  <= fin_q.min_valid ? fin_min_slot_q : '0;
				end
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= rsp_n;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/stt_cell.sv =====
// one timer slot of the chain: holds its entry and updates the passing bundle
// depends on stt_pkg
module stt_cell #(
	parameter int SLOT_W = 4,
	parameter int INDEX  = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  stt_pkg::cmd_t       cmd,
	input  logic [SLOT_W-1:0]   fire_slot,
	input  stt_pkg::link_t      up,
	input  logic [SLOT_W-1:0]   up_min_slot,
	input  logic [SLOT_W-1:0]   up_hit_slot,
	output stt_pkg::link_t      dn,
	output logic [SLOT_W-1:0]   dn_min_slot,
	output logic [SLOT_W-1:0]   dn_hit_slot
);

	localparam logic [SLOT_W-1:0] SELF = SLOT_W'(INDEX);

	logic        active_q;
	logic [7:0]  event_q;
	logic [31:0] period_q;
	logic        repeat_q;
	logic [31:0] deadline_q;

	stt_pkg::link_t    dn_q;
	logic [SLOT_W-1:0] min_slot_q;
	logic [SLOT_W-1:0] hit_slot_q;

	logic        do_add, do_rem, do_fire, hit, active_n, take_min;
	logic [31:0] dl_n;

	always_comb begin
		do_add  = up.tok && (cmd.op == stt_pkg::OP_ADD) && !up.found && !active_q;
		do_rem  = up.tok && (cmd.op == stt_pkg::OP_REMOVE) && !up.found && active_q &&
			(event_q == cmd.event_id);
		do_fire = up.tok && (cmd.op == stt_pkg::OP_POLL) && cmd.fire_en &&
			(fire_slot == SELF) && active_q;
		hit     = do_add || do_rem || do_fire;

		if (do_add) begin
			active_n = 1'b1;
		end else if (do_rem || (do_fire && !repeat_q)) begin
			active_n = 1'b0;
		end else begin
			active_n = active_q;
		end

		if (do_add) begin
			dl_n = cmd.add_dl;
		end else if (do_fire) begin
			dl_n = deadline_q + period_q;
		end else begin
			dl_n = deadline_q;
		end

		// strict compare keeps the lower index on ties
		take_min = active_n && (!up.min_valid || (dl_n < up.min_dl));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (up.tok) begin
			active_q <= active_n;
		end
	end

	always_ff @(posedge clk) begin
		if (do_add) begin
			event_q  <= cmd.event_id;
			period_q <= cmd.period;
			repeat_q <= cmd.repeat_en;
		end
		if (do_add || do_fire) begin
			deadline_q <= dl_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_q       <= '0;
			min_slot_q <= '0;
			hit_slot_q <= '0;
		end else begin
			dn_q.tok       <= up.tok;
			dn_q.found     <= up.found || hit;
			dn_q.hit_dl    <= hit ? dl_n : up.hit_dl;
			dn_q.hit_event <= hit ? event_q : up.hit_event;
			hit_slot_q     <= hit ? SELF : up_hit_slot;
			dn_q.min_valid <= up.min_valid || take_min;
			dn_q.min_dl    <= take_min ? dl_n : up.min_dl;
			min_slot_q     <= take_min ? SELF : up_min_slot;
		end
	end

	assign dn          = dn_q;
	assign dn_min_slot = min_slot_q;
	assign dn_hit_slot = hit_slot_q;

endmodule
